@@ rtl/core/blp_pkg.sv @@
package blp_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 32;

  // Command codes carried in the cmd field.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_t;

endpackage

@@ rtl/core/blp_setup.sv @@
// Line set-up: picks the major axis, orders the endpoints along it and
// derives the span, the doubled minor length and the minor direction.
module blp_setup #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] xa_i,
  input  logic [COORD_BITS-1:0] ya_i,
  input  logic [COORD_BITS-1:0] xb_i,
  input  logic [COORD_BITS-1:0] yb_i,
  output logic                  steep_o,
  output logic [COORD_BITS-1:0] major_start_o,
  output logic [COORD_BITS-1:0] major_end_o,
  output logic [COORD_BITS-1:0] minor_start_o,
  output logic                  minor_down_o,
  output logic [COORD_BITS-1:0] major_span_o,
  output logic [COORD_BITS:0]   err_inc_o
);

  logic                  x_gt, x_lt, y_gt, y_lt;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  minor_up;

  assign x_gt = xa_i > xb_i;
  assign x_lt = xa_i < xb_i;
  assign y_gt = ya_i > yb_i;
  assign y_lt = ya_i < yb_i;

  assign adx = x_gt ? (xa_i - xb_i) : (xb_i - xa_i);
  assign ady = y_gt ? (ya_i - yb_i) : (yb_i - ya_i);

  // Equal spans count as shallow.
  assign steep_o = adx < ady;

  always_comb begin
    if (steep_o) begin
      major_start_o = y_gt ? yb_i : ya_i;
      major_end_o   = y_gt ? ya_i : yb_i;
      minor_start_o = y_gt ? xb_i : xa_i;
      minor_up      = y_gt ? x_gt : x_lt;
      major_span_o  = ady;
      err_inc_o     = {adx, 1'b0};
    end else begin
      major_start_o = x_gt ? xb_i : xa_i;
      major_end_o   = x_gt ? xa_i : xb_i;
      minor_start_o = x_gt ? yb_i : ya_i;
      minor_up      = x_gt ? y_gt : y_lt;
      major_span_o  = adx;
      err_inc_o     = {ady, 1'b0};
    end
  end

  assign minor_down_o = !minor_up;

endmodule

@@ rtl/core/bresenham_line_pixels.sv @@
// Bresenham line pixel generator.
// Timing: a step transaction's pixel is registered and appears on the output in the cycle after it is accepted.
// Throughput: one transaction per cycle; the single output register is refilled in the
// cycle it is emptied, so the input stalls only while a pixel waits and the output stalls.
// Reset: asynchronous, active low; it clears the output valid flag and leaves no line active.
module bresenham_line_pixels #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  blp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output blp_pkg::out_t out_data_o
);

  localparam int unsigned CoordW = blp_pkg::COORD_W;
  // Wide enough for both the field width and the internal coordinate width.
  localparam int unsigned ExtW   = (COORD_BITS > CoordW) ? COORD_BITS : CoordW;
  // The error term lies within plus and minus the span, and before the
  // correction it may reach three spans, so it needs three bits over a coordinate.
  localparam int unsigned AccW   = COORD_BITS + 3;

  // Line state. A load fills it; each step transaction advances it.
  logic                         active_q, active_d;
  logic                         steep_q, steep_d;
  logic        [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic        [COORD_BITS-1:0] major_end_q, major_end_d;
  logic        [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic                         minor_down_q, minor_down_d;
  logic        [COORD_BITS-1:0] major_span_q, major_span_d;
  logic        [COORD_BITS:0]   err_inc_q, err_inc_d;
  logic signed [AccW-1:0]       err_acc_q, err_acc_d;
  logic        [blp_pkg::COLOR_W-1:0] line_color_q, line_color_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  blp_pkg::out_t out_data_q, out_data_d;

  logic out_ready;
  logic in_fire;
  logic is_load;
  logic emit;
  logic last;

  // Endpoints brought to the internal coordinate width.
  logic [ExtW-1:0]       xa_ext, ya_ext, xb_ext, yb_ext;
  logic [COORD_BITS-1:0] xa, ya, xb, yb;

  // Set-up results for a load transaction.
  logic                  su_steep;
  logic [COORD_BITS-1:0] su_major_start, su_major_end, su_minor_start;
  logic                  su_minor_down;
  logic [COORD_BITS-1:0] su_major_span;
  logic [COORD_BITS:0]   su_err_inc;

  // Step arithmetic.
  logic signed [AccW-1:0] span_s;
  logic signed [AccW-1:0] acc_sum;
  logic                   minor_move;

  // Screen-axis pixel before truncation to the field width.
  logic [COORD_BITS-1:0] px, py;
  logic [ExtW-1:0]       px_ext, py_ext;

  // The output register can take a new pixel when it is empty or being
  // emptied in this cycle. Loads wait too, which keeps the ordering simple.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_ready;
  assign in_fire    = in_valid_i && out_ready;
  assign is_load    = in_data_i.cmd == blp_pkg::CMD_LOAD;
  assign emit       = in_fire && !is_load && active_q;
  assign last       = major_pos_q == major_end_q;

  assign xa_ext = ExtW'(in_data_i.x_start);
  assign ya_ext = ExtW'(in_data_i.y_start);
  assign xb_ext = ExtW'(in_data_i.x_end);
  assign yb_ext = ExtW'(in_data_i.y_end);
  assign xa     = xa_ext[COORD_BITS-1:0];
  assign ya     = ya_ext[COORD_BITS-1:0];
  assign xb     = xb_ext[COORD_BITS-1:0];
  assign yb     = yb_ext[COORD_BITS-1:0];

  blp_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .xa_i         (xa),
    .ya_i         (ya),
    .xb_i         (xb),
    .yb_i         (yb),
    .steep_o      (su_steep),
    .major_start_o(su_major_start),
    .major_end_o  (su_major_end),
    .minor_start_o(su_minor_start),
    .minor_down_o (su_minor_down),
    .major_span_o (su_major_span),
    .err_inc_o    (su_err_inc)
  );

  // The minor axis moves once the accumulated error passes the span; the
  // doubled span is then taken off again.
  assign span_s     = $signed(AccW'(major_span_q));
  assign acc_sum    = err_acc_q + $signed(AccW'(err_inc_q));
  assign minor_move = acc_sum > span_s;

  // Swap back to screen axes for a steep line.
  assign px     = steep_q ? minor_pos_q : major_pos_q;
  assign py     = steep_q ? major_pos_q : minor_pos_q;
  assign px_ext = ExtW'(px);
  assign py_ext = ExtW'(py);

  always_comb begin
    active_d     = active_q;
    steep_d      = steep_q;
    major_pos_d  = major_pos_q;
    major_end_d  = major_end_q;
    minor_pos_d  = minor_pos_q;
    minor_down_d = minor_down_q;
    major_span_d = major_span_q;
    err_inc_d    = err_inc_q;
    err_acc_d    = err_acc_q;
    line_color_d = line_color_q;

    if (in_fire && is_load) begin
      // A load replaces any line still being drawn.
      active_d     = 1'b1;
      steep_d      = su_steep;
      major_pos_d  = su_major_start;
      major_end_d  = su_major_end;
      minor_pos_d  = su_minor_start;
      minor_down_d = su_minor_down;
      major_span_d = su_major_span;
      err_inc_d    = su_err_inc;
      err_acc_d    = '0;
      line_color_d = in_data_i.color;
    end else if (emit) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + 1'b1;
        if (minor_move) begin
          minor_pos_d = minor_down_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
          err_acc_d   = acc_sum - (span_s <<< 1);
        end else begin
          err_acc_d   = acc_sum;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = emit;
    end
    out_data_d             = out_data_q;
    if (emit) begin
      out_data_d.pixel_x     = px_ext[CoordW-1:0];
      out_data_d.pixel_y     = py_ext[CoordW-1:0];
      out_data_d.pixel_color = line_color_q;
      out_data_d.last_pixel  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      steep_q      <= 1'b0;
      major_pos_q  <= '0;
      major_end_q  <= '0;
      minor_pos_q  <= '0;
      minor_down_q <= 1'b0;
      major_span_q <= '0;
      err_inc_q    <= '0;
      err_acc_q    <= '0;
      line_color_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      steep_q      <= steep_d;
      major_pos_q  <= major_pos_d;
      major_end_q  <= major_end_d;
      minor_pos_q  <= minor_pos_d;
      minor_down_q <= minor_down_d;
      major_span_q <= major_span_d;
      err_inc_q    <= err_inc_d;
      err_acc_q    <= err_acc_d;
      line_color_q <= line_color_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Pixel payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The input is held back only while a pixel is waiting at the output.
  a_stall_needs_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty output register");

  // An accepted load always leaves a line active.
  a_load_activates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_load) |=> active_q)
    else $error("load transaction did not start a line");

  // Emitting the final pixel ends the line and flags it.
  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (!active_q && out_valid_q && out_data_q.last_pixel))
    else $error("final pixel did not end the line");

  // The major position never runs past the end of an active line.
  a_major_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (major_pos_q <= major_end_q))
    else $error("major position beyond line end");

  // The error term stays within one span either side of zero.
  a_err_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((err_acc_q <= span_s) && (err_acc_q >= -span_s)))
    else $error("error term out of range");

endmodule

@@ dv/blp_pixel_checker.sv @@
module blp_pixel_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  blp_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  blp_pkg::out_t  out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  // Own copy of the line walker's state.
  logic                               line_active;
  logic                               line_steep;
  logic [blp_pkg::COORD_W-1:0]        major_pos;
  logic [blp_pkg::COORD_W-1:0]        major_end;
  logic [blp_pkg::COORD_W-1:0]        minor_pos;
  logic                               minor_down;
  logic [blp_pkg::COORD_W-1:0]        major_span;
  logic [blp_pkg::COORD_W:0]          err_inc;
  logic signed [blp_pkg::COORD_W+2:0] err_acc;
  logic [blp_pkg::COLOR_W-1:0]        line_color;

  blp_pkg::out_t pixels_due[$];

  initial fail_count_o = 0;

  // Applies one accepted transaction; returns 1 with the pixel when one is drawn.
  function automatic bit trace_pixel(input blp_pkg::in_t item, output blp_pkg::out_t pixel);
    logic [blp_pkg::COORD_W-1:0]        adx, ady, ma, na, mb, nb, tmp;
    logic                               steep_now;
    logic signed [blp_pkg::COORD_W+2:0] acc_next;
    pixel = '0;
    if (item.cmd == blp_pkg::CMD_LOAD) begin
      adx = (item.x_start > item.x_end) ? item.x_start - item.x_end
                                        : item.x_end - item.x_start;
      ady = (item.y_start > item.y_end) ? item.y_start - item.y_end
                                        : item.y_end - item.y_start;
      steep_now = adx < ady;
      if (steep_now) begin
        ma = item.y_start; na = item.x_start; mb = item.y_end; nb = item.x_end;
      end else begin
        ma = item.x_start; na = item.y_start; mb = item.x_end; nb = item.y_end;
      end
      if (ma > mb) begin
        tmp = ma; ma = mb; mb = tmp;
        tmp = na; na = nb; nb = tmp;
      end
      line_active = 1'b1;
      line_steep  = steep_now;
      major_pos   = ma;
      major_end   = mb;
      minor_pos   = na;
      minor_down  = !(nb > na);
      major_span  = mb - ma;
      tmp         = (nb > na) ? nb - na : na - nb;
      err_inc     = {tmp, 1'b0};
      err_acc     = '0;
      line_color  = item.color;
      return 1'b0;
    end
    if (!line_active) return 1'b0;
    pixel.pixel_x     = line_steep ? minor_pos : major_pos;
    pixel.pixel_y     = line_steep ? major_pos : minor_pos;
    pixel.pixel_color = line_color;
    pixel.last_pixel  = (major_pos == major_end);
    if (pixel.last_pixel) begin
      line_active = 1'b0;
    end else begin
      major_pos = major_pos + 1'b1;
      acc_next  = err_acc + $signed({2'b00, err_inc});
      if (acc_next > $signed({3'b000, major_span})) begin
        minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        acc_next  = acc_next - $signed({2'b00, major_span, 1'b0});
      end
      err_acc = acc_next;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    blp_pkg::out_t want;
    if (!rst_ni) begin
      line_active = 1'b0;
      line_steep  = 1'b0;
      major_pos   = '0;
      major_end   = '0;
      minor_pos   = '0;
      minor_down  = 1'b0;
      major_span  = '0;
      err_inc     = '0;
      err_acc     = '0;
      line_color  = '0;
      pixels_due.delete();
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel x=0x%0h y=0x%0h", out_data_i.pixel_x, out_data_i.pixel_y);
          fail_count_o++;
        end else begin
          want = pixels_due.pop_front();
          check_field("pixel_x", 32'(want.pixel_x), 32'(out_data_i.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(out_data_i.pixel_y));
          check_field("pixel_color", want.pixel_color, out_data_i.pixel_color);
          check_field("last_pixel", 32'(want.last_pixel), 32'(out_data_i.last_pixel));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (trace_pixel(in_data_i, want)) pixels_due.push_back(want);
      end
      pending_o <= pixels_due.size();
    end
  end

endmodule

@@ dv/bresenham_line_pixels_tb.sv @@
module bresenham_line_pixels_tb;

  localparam int unsigned COORD_W     = blp_pkg::COORD_W;
  // Stimulus stops once this many transactions have been accepted.
  localparam int unsigned ITEM_TARGET = 1550;
  // The sender holds off until every pixel is out roughly this often.
  localparam int unsigned DRAIN_EVERY = 300;
  localparam int          COORD_MAX   = (1 << COORD_W) - 1;

  // The receiver cycles through these stall behaviours in turn.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_BURSTS
  } stall_mode_e;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  blp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  blp_pkg::out_t out_data;
  int unsigned   fail_count;
  int unsigned   pending;

  int unsigned sent_count;
  int unsigned burst_left;
  int unsigned next_drain;
  logic [8:0]  stall_phase;
  logic [2:0]  stall_hold;

  bresenham_line_pixels #(
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // The checker watches both channels, predicts every pixel and compares.
  blp_pixel_checker pixel_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver back-pressure. Each mode lasts long enough that stalls land on
  // every phase of a line, and the quiet mode gives stretches of full rate.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_mode_e'(stall_phase[8:7]))
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      STALL_PERIODIC: begin
        out_stall <= (stall_phase[2:0] < 3'd3);
      end
      default: begin
        if (stall_hold != 0) begin
          stall_hold <= stall_hold - 1'b1;
          out_stall  <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_hold <= 3'($urandom_range(1, 6));
          out_stall  <= 1'b1;
        end else begin
          out_stall  <= 1'b0;
        end
      end
    endcase
  end

  // Offers one transaction and returns at the edge where it is accepted. The
  // sender works in bursts; when a burst is used up it idles for a while first.
  // A gap always waits on the clock, so valid is never lowered and raised
  // again within the same time step.
  task automatic send_item(input blp_pkg::in_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Every field random; the coordinate and colour fields of a step are
  // ignored by the block but still exercised.
  function automatic blp_pkg::in_t noise_item(input logic cmd);
    blp_pkg::in_t item;
    item.cmd     = cmd;
    item.x_start = COORD_W'($urandom);
    item.y_start = COORD_W'($urandom);
    item.x_end   = COORD_W'($urandom);
    item.y_end   = COORD_W'($urandom);
    item.color   = $urandom;
    return item;
  endfunction

  task automatic load_line(input int xs, input int ys, input int xe, input int ye,
                           input logic [blp_pkg::COLOR_W-1:0] col);
    blp_pkg::in_t item;
    item         = noise_item(blp_pkg::CMD_LOAD);
    item.x_start = COORD_W'(xs);
    item.y_start = COORD_W'(ys);
    item.x_end   = COORD_W'(xe);
    item.y_end   = COORD_W'(ye);
    item.color   = col;
    send_item(item);
  endtask

  task automatic step_line(input int unsigned count);
    repeat (count) send_item(noise_item(blp_pkg::CMD_STEP));
  endtask

  // Stops offering transactions until every predicted pixel has come out. The
  // first edge lets the checker count the transaction accepted just before.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Screen coordinate with the edges of the screen well represented.
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Mostly short, well-formed lines drawn to the end, so that the error term
  // and both step directions get a full workout. The rest are lines cut short
  // by a new load, long lines that are abandoned, and stray transactions.
  task automatic random_line();
    int x0, y0, x1, y1, dx, dy, reach, pixels, kind;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      reach = ($urandom_range(0, 7) == 0) ? 60 : 10;
      x0    = pick_coord();
      y0    = pick_coord();
      dx    = $urandom_range(0, 2 * reach) - reach;
      dy    = $urandom_range(0, 2 * reach) - reach;
      x1    = (x0 + dx >= 0 && x0 + dx <= COORD_MAX) ? x0 + dx : x0 - dx;
      y1    = (y0 + dy >= 0 && y0 + dy <= COORD_MAX) ? y0 + dy : y0 - dy;
      dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
      pixels = ((dx > dy) ? dx : dy) + 1;
      load_line(x0, y0, x1, y1, $urandom);
      case ($urandom_range(0, 9))
        // Cut short: the next load takes over a line still in progress.
        0:       step_line($urandom_range(0, pixels - 1));
        // Overrun: the extra steps find the block idle and draw nothing.
        1, 2:    step_line(pixels + $urandom_range(1, 2));
        default: step_line(pixels);
      endcase
    end else if (kind < 90) begin
      load_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(), $urandom);
      step_line($urandom_range(0, 6));
    end else begin
      send_item(noise_item(1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    stall_phase = '0;
    stall_hold  = '0;
    burst_left  = 0;
    sent_count  = 0;
    next_drain  = DRAIN_EVERY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A step straight after reset finds no line and must draw nothing.
    step_line(1);
    // Single-point line with an all-ones colour; the second step finds the
    // block idle again after the final pixel.
    load_line(100, 200, 100, 200, 32'hFFFF_FFFF);
    step_line(2);
    // Equal spans count as shallow; the endpoints are reordered and the
    // minor axis runs downward toward the screen's right edge.
    load_line(COORD_MAX, 0, COORD_MAX - 3, 3, 32'h0000_0000);
    step_line(4);
    // Steep line at the bottom edge: axes are swapped and swapped back.
    load_line(7, COORD_MAX, 8, COORD_MAX - 3, 32'hA5A5_5A5A);
    step_line(4);
    // A full-screen diagonal is replaced part way by a point in the far corner.
    load_line(0, 0, COORD_MAX, COORD_MAX, 32'h1234_5678);
    step_line(2);
    load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0000_0000);
    step_line(1);
    // Shallow line given right to left, with one minor step along the way.
    load_line(3, 1, 0, 2, 32'h8000_0001);
    step_line(4);

    while (sent_count < ITEM_TARGET) begin
      random_line();
      if (sent_count >= next_drain) begin
        drain_pixels();
        next_drain += DRAIN_EVERY;
      end
    end

    // Let every outstanding pixel out, then keep the clock running so that
    // a stray pixel from the output register would still be caught.
    drain_pixels();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bresenham_line_pixels regression: pass");
    end else begin
      $display("bresenham_line_pixels regression: fail");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #400000;
    $display("bresenham_line_pixels regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/blp_pkg.sv
rtl/core/blp_setup.sv
rtl/core/bresenham_line_pixels.sv
dv/blp_pixel_checker.sv
dv/bresenham_line_pixels_tb.sv
